// ===== src/htbd_pkg.sv =====
// shared types and constants for the huffman tree bit decoder
package htbd_pkg;

	// default sizes
	localparam int MAX_NODES_DEF    = 512;
	localparam int MAX_CODE_LEN_DEF = 16;

	// result status codes
	localparam logic [2:0] ST_ACK     = 3'd0;
	localparam logic [2:0] ST_SYMBOL  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_BADLEN  = 3'd4;

	// node table read address source
	typedef enum logic [1:0] {
		RA_ROOT,
		RA_WALK,
		RA_CHILD,
		RA_FREE
	} rd_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		rd_sel_t    rd_sel;
		logic       step;
		logic       alloc;
		logic       link;
		logic       emit;
		logic [2:0] emit_status;
		logic       walk_root;
		logic       walk_child;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic child_zero;
		logic child_leaf;
		logic table_full;
		logic last_bit;
		logic len_bad;
	} ctrl_stat_t;

endpackage

// ===== src/huffman_tree_bit_decoder_core.sv =====
// decode bit: taken into the decode state, strobe registered from it; no new one until idle
// load: taken in idle, then evaluate per existing path node, evaluate and link per created node
// bad length: result strobe in the cycle after the transaction; the next one is taken with it
// each step costs one registered read of the child pointer memories
// result is held on the ports for one cycle with done high; the receiver cannot stall
// reset: empty tree (root children in flip-flops), walk at root, no clearing pass;
// nodes are cleared as they are allocated
module huffman_tree_bit_decoder_core #(
	parameter int MAX_NODES    = htbd_pkg::MAX_NODES_DEF,
	parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] code_bits,
	input  logic [4:0]  code_length,
	input  logic [7:0]  load_symbol,
	input  logic        coded_bit,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  out_symbol
);

	htbd_pkg::ctrl_cmd_t  cmd;
	htbd_pkg::ctrl_stat_t stat;

	// sequencing
	htbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// node table and result
	htbd_datapath #(
		.MAX_NODES    (MAX_NODES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.code_bits   (code_bits),
		.code_length (code_length),
		.load_symbol (load_symbol),
		.coded_bit   (coded_bit),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.out_symbol  (out_symbol)
	);

endmodule

// ===== src/htbd_datapath.sv =====
// node table, walk registers and result register of the huffman tree decoder
module htbd_datapath #(
	parameter int MAX_NODES    = htbd_pkg::MAX_NODES_DEF,
	parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mode,
	input  logic [15:0]          code_bits,
	input  logic [4:0]           code_length,
	input  logic [7:0]           load_symbol,
	input  logic                 coded_bit,
	input  htbd_pkg::ctrl_cmd_t  cmd,
	output htbd_pkg::ctrl_stat_t stat,
	output logic                 done,
	output logic [2:0]           status,
	output logic [7:0]           out_symbol
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NFW = $clog2(MAX_NODES + 1);
	localparam int EW  = NW + 9;
	localparam int CW  = MAX_CODE_LEN;
	localparam int LW  = $clog2(MAX_CODE_LEN + 1);

	// child entries hold leaf flag, symbol and pointer of the child
	logic [EW-1:0]  left_mem  [MAX_NODES];
	logic [EW-1:0]  right_mem [MAX_NODES];
	logic [EW-1:0]  left_rd_q;
	logic [EW-1:0]  right_rd_q;
	logic           root_rd_q;
	logic [EW-1:0]  root_left_q;
	logic [EW-1:0]  root_right_q;

	logic [CW-1:0]  code_q;
	logic [LW-1:0]  bits_left_q;
	logic [7:0]     sym_q;
	logic [NW-1:0]  node_q;
	logic [NFW-1:0] free_q;
	logic [NW-1:0]  walk_q;
	logic           done_q;
	logic [2:0]     status_q;
	logic [7:0]     out_symbol_q;

	logic           cur_bit;
	logic [EW-1:0]  child;
	logic [NW-1:0]  child_ptr;
	logic [NW-1:0]  free_idx;
	logic [EW-1:0]  new_entry;
	logic [NW-1:0]  rd_addr;
	logic [4:0]     code_shamt;
	logic           root_parent;
	logic           l_we;
	logic [NW-1:0]  l_addr;
	logic [EW-1:0]  l_wdata;
	logic           r_we;
	logic [NW-1:0]  r_addr;
	logic [EW-1:0]  r_wdata;

	// current bit is always the top of the code register
	assign cur_bit   = code_q[CW-1];
	assign free_idx  = free_q[NW-1:0];
	assign child     = root_rd_q ? (cur_bit ? root_right_q : root_left_q)
	                             : (cur_bit ? right_rd_q : left_rd_q);
	assign child_ptr = child[NW-1:0];
	assign new_entry = {stat.last_bit, sym_q, free_idx};
	assign root_parent = (node_q == '0);
	assign code_shamt  = 5'(MAX_CODE_LEN) - code_length;

	// status towards the controller
	assign stat.child_zero = (child_ptr == '0);
	assign stat.child_leaf = child[EW-1];
	assign stat.table_full = (free_q == NFW'(MAX_NODES));
	assign stat.last_bit   = (bits_left_q == LW'(1));
	assign stat.len_bad    = (code_length == 5'd0) || (code_length > 5'(MAX_CODE_LEN));

	// read address selection
	always_comb begin
		case (cmd.rd_sel)
			htbd_pkg::RA_ROOT:  rd_addr = '0;
			htbd_pkg::RA_WALK:  rd_addr = walk_q;
			htbd_pkg::RA_CHILD: rd_addr = child_ptr;
			htbd_pkg::RA_FREE:  rd_addr = free_idx;
			default:            rd_addr = '0;
		endcase
	end

	// write ports: clear a fresh node, or link a child into a non-root parent
	always_comb begin
		l_we    = 1'b0;
		l_addr  = free_idx;
		l_wdata = '0;
		r_we    = 1'b0;
		r_addr  = free_idx;
		r_wdata = '0;
		if (cmd.alloc) begin
			l_we = 1'b1;
			r_we = 1'b1;
		end else if (cmd.link && !root_parent) begin
			if (cur_bit) begin
				r_we    = 1'b1;
				r_addr  = node_q;
				r_wdata = new_entry;
			end else begin
				l_we    = 1'b1;
				l_addr  = node_q;
				l_wdata = new_entry;
			end
		end
	end

	// node table memories
	always_ff @(posedge clk) begin
		if (l_we) begin
			left_mem[l_addr] <= l_wdata;
		end
		if (r_we) begin
			right_mem[r_addr] <= r_wdata;
		end
		left_rd_q  <= left_mem[rd_addr];
		right_rd_q <= right_mem[rd_addr];
	end

	// transaction payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sym_q       <= load_symbol;
			bits_left_q <= LW'(code_length);
			if (mode) begin
				code_q <= CW'(coded_bit) << (CW - 1);
			end else begin
				code_q <= CW'(code_bits) << code_shamt;
			end
		end else if (cmd.step || cmd.link) begin
			code_q      <= code_q << 1;
			bits_left_q <= bits_left_q - LW'(1);
		end
		if (cmd.capture) begin
			node_q <= '0;
		end else if (cmd.step) begin
			node_q <= child_ptr;
		end else if (cmd.link) begin
			node_q <= free_idx;
		end
		if (cmd.emit) begin
			status_q     <= cmd.emit_status;
			out_symbol_q <= (cmd.emit_status == htbd_pkg::ST_SYMBOL) ? child[EW-2:NW] : 8'd0;
		end
	end

	// state that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_rd_q    <= 1'b0;
			root_left_q  <= '0;
			root_right_q <= '0;
			free_q       <= NFW'(1);
			walk_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			root_rd_q <= (rd_addr == '0);
			done_q    <= cmd.emit;
			if (cmd.link) begin
				free_q <= free_q + NFW'(1);
				if (root_parent) begin
					if (cur_bit) begin
						root_right_q <= new_entry;
					end else begin
						root_left_q <= new_entry;
					end
				end
			end
			if (cmd.walk_root) begin
				walk_q <= '0;
			end else if (cmd.walk_child) begin
				walk_q <= child_ptr;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_symbol = out_symbol_q;

endmodule

// ===== src/htbd_ctrl.sv =====
// sequencing state machine of the huffman tree decoder
module htbd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 mode,
	input  htbd_pkg::ctrl_stat_t stat,
	output htbd_pkg::ctrl_cmd_t  cmd,
	output logic                 busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD_EVAL,
		S_LOAD_LINK,
		S_DEC_EVAL
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   busy_q;

	// next state and commands
	always_comb begin
		state_nxt       = state_q;
		cmd             = '0;
		cmd.rd_sel      = htbd_pkg::RA_ROOT;
		cmd.emit_status = htbd_pkg::ST_ACK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (mode) begin
						cmd.rd_sel = htbd_pkg::RA_WALK;
						state_nxt  = S_DEC_EVAL;
					end else if (stat.len_bad) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = htbd_pkg::ST_BADLEN;
					end else begin
						state_nxt = S_LOAD_EVAL;
					end
				end
			end
			S_LOAD_EVAL: begin
				if (!stat.child_zero) begin
					cmd.step = 1'b1;
					if (stat.last_bit) begin
						cmd.emit  = 1'b1;
						state_nxt = S_IDLE;
					end else begin
						cmd.rd_sel = htbd_pkg::RA_CHILD;
					end
				end else if (stat.table_full) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = htbd_pkg::ST_FULL;
					state_nxt       = S_IDLE;
				end else begin
					cmd.alloc = 1'b1;
					state_nxt = S_LOAD_LINK;
				end
			end
			S_LOAD_LINK: begin
				cmd.link   = 1'b1;
				cmd.rd_sel = htbd_pkg::RA_FREE;
				if (stat.last_bit) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_LOAD_EVAL;
				end
			end
			S_DEC_EVAL: begin
				cmd.emit  = 1'b1;
				state_nxt = S_IDLE;
				if (stat.child_zero) begin
					cmd.emit_status = htbd_pkg::ST_MISSING;
					cmd.walk_root   = 1'b1;
				end else if (stat.child_leaf) begin
					cmd.emit_status = htbd_pkg::ST_SYMBOL;
					cmd.walk_root   = 1'b1;
				end else begin
					cmd.walk_child = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy_q  <= (state_nxt != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule
